FILE: design/ppu_scanline_fetch_sequencer_macros.svh
// assertion macros for the scanline fetch sequencer
`ifndef PPU_SCANLINE_FETCH_SEQUENCER_MACROS_SVH
`define PPU_SCANLINE_FETCH_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFS_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFS_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ppu_sfs_pkg.sv
// shared types and constants of the scanline fetch sequencer
package ppu_sfs_pkg;

  // fetch kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_NAME   = 3'd1;
  localparam logic [2:0] KIND_ATTR   = 3'd2;
  localparam logic [2:0] KIND_PLO    = 3'd3;
  localparam logic [2:0] KIND_PHI    = 3'd4;

  // dot phase within an eight-dot fetch group
  localparam logic [2:0] PHASE_NAME  = 3'd2;
  localparam logic [2:0] PHASE_ATTR  = 3'd4;
  localparam logic [2:0] PHASE_PLO   = 3'd6;
  localparam logic [2:0] PHASE_PHI   = 3'd0;

  // configuration register indexes
  localparam int unsigned REG_SCROLL_T     = 0;
  localparam int unsigned REG_PATTERN_HALF = 1;

  // timing
  localparam logic [8:0] LAST_DOT      = 9'd340;
  localparam logic [8:0] NMI_LINE      = 9'd241;
  localparam logic [8:0] PRE_LINE      = 9'd261;
  localparam logic [8:0] FIRST_IDLE    = 9'd240;
  localparam logic [8:0] WIN_A_END     = 9'd256;
  localparam logic [8:0] WIN_B_START   = 9'd321;
  localparam logic [8:0] HORI_DOT      = 9'd257;
  localparam logic [8:0] VERT_FIRST    = 9'd280;
  localparam logic [8:0] VERT_LAST     = 9'd304;

  // scroll copy masks and address bases
  localparam logic [14:0] HORI_MASK    = 15'h041F;
  localparam logic [14:0] VERT_MASK    = 15'h7BE0;
  localparam logic [13:0] NAME_BASE    = 14'h2000;
  localparam logic [13:0] ATTR_BASE    = 14'h23C0;

  // sequencer state
  typedef struct packed {
    logic [14:0] v;
    logic [8:0]  dot;
    logic [8:0]  line;
    logic        odd;
    logic [15:0] name_sh;
    logic [15:0] attr_sh;
    logic [15:0] plo_sh;
    logic [15:0] phi_sh;
    logic        nmi;
  } state_t;

  // per-tick fetch result
  typedef struct packed {
    logic [2:0]  kind;
    logic [13:0] addr;
    logic        clr;
  } fetch_t;

endpackage

FILE: design/ppu_scanline_fetch_sequencer.sv
// Background fetch sequencer with loopy scroll: one input word per dot tick carries the byte
// that memory returns for the fetch issued on that same tick; one result word per tick gives
// the fetch issued, the new position, v, the interrupt level and the four byte histories. It
// sustains one word per clock while the result word is not stalled; a word taken waits in the
// input register, and the step logic's state update and fetch are registered together into the
// sequencer state and result registers. While the result word is stalled the input register
// holds one further word. Configuration (scroll t at index 0, pattern half at index 1) is
// always ready; other indexes are ignored.
module ppu_scanline_fetch_sequencer #(
  parameter int CfgIndexWidth = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_read_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_fetch_kind,
  output logic [13:0]              out_fetch_address,
  output logic [8:0]               out_dot_now,
  output logic [8:0]               out_line_now,
  output logic [14:0]              out_scroll_v,
  output logic                     out_nmi_active,
  output logic                     out_status_clear,
  output logic [15:0]              out_name_history,
  output logic [15:0]              out_attr_history,
  output logic [15:0]              out_plane_low_history,
  output logic [15:0]              out_plane_high_history,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [14:0]              cfg_data
);

  `include "ppu_scanline_fetch_sequencer_macros.svh"

  logic                in_valid_r;
  logic [7:0]          in_data_r;
  logic                out_valid_r;
  logic [14:0]         scroll_t_r;
  logic                pattern_half_r;
  ppu_sfs_pkg::state_t state_r;
  ppu_sfs_pkg::state_t state_nxt;
  ppu_sfs_pkg::fetch_t fetch_nxt;
  ppu_sfs_pkg::fetch_t fetch_r;
  logic                step_go;
  logic                in_take;

  // handshake
  assign step_go   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !step_go;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_t_r     <= '0;
      pattern_half_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgIndexWidth'(ppu_sfs_pkg::REG_SCROLL_T)) begin
        scroll_t_r <= cfg_data;
      end else if (cfg_index == CfgIndexWidth'(ppu_sfs_pkg::REG_PATTERN_HALF)) begin
        pattern_half_r <= cfg_data[0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_read_data;
    end
  end

  // step logic
  ppu_sfs_step u_step (
    .cur          (state_r),
    .rd           (in_data_r),
    .scroll_t     (scroll_t_r),
    .pattern_half (pattern_half_r),
    .nxt          (state_nxt),
    .fetch        (fetch_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      fetch_r <= fetch_nxt;
    end
  end

  // result word: fetch of this tick and state after it
  assign out_fetch_kind         = fetch_r.kind;
  assign out_fetch_address      = fetch_r.addr;
  assign out_status_clear       = fetch_r.clr;
  assign out_dot_now            = state_r.dot;
  assign out_line_now           = state_r.line;
  assign out_scroll_v           = state_r.v;
  assign out_nmi_active         = state_r.nmi;
  assign out_name_history       = state_r.name_sh;
  assign out_attr_history       = state_r.attr_sh;
  assign out_plane_low_history  = state_r.plo_sh;
  assign out_plane_high_history = state_r.phi_sh;

  // checks
  `SFS_CHECK_IMP(a_dot_range, 1'b1, state_r.dot <= ppu_sfs_pkg::LAST_DOT, "dot beyond line end")
  `SFS_CHECK_IMP(a_no_fetch_addr, out_valid_r && (fetch_r.kind == ppu_sfs_pkg::KIND_NONE), fetch_r.addr == 14'd0, "address without fetch")
  `SFS_CHECK_IMP(a_clr_nmi, out_valid_r && fetch_r.clr, !state_r.nmi && (state_r.dot == 9'd2), "status clear out of place")
  `SFS_CHECK_NXT(a_step_out, step_go, out_valid_r, "stepped word not presented")

endmodule

FILE: design/ppu_sfs_step.sv
// next-state and fetch logic for one dot tick
module ppu_sfs_step (
  input  ppu_sfs_pkg::state_t cur,
  input  logic [7:0]          rd,
  input  logic [14:0]         scroll_t,
  input  logic                pattern_half,
  output ppu_sfs_pkg::state_t nxt,
  output ppu_sfs_pkg::fetch_t fetch
);

  // coarse-x increment with horizontal nametable wrap
  function automatic logic [14:0] coarse_x(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[4:0] == 5'h1F) begin
      r[4:0] = 5'h00;
      r[10]  = ~v[10];
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

  // fine-y increment spilling into coarse y
  function automatic logic [14:0] fine_y(input logic [14:0] v);
    logic [14:0] r;
    logic [4:0]  cy;
    r  = v;
    cy = v[9:5];
    if (v[14:12] != 3'd7) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (cy == 5'd29) begin
        cy    = 5'd0;
        r[11] = ~v[11];
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r[9:5] = cy;
    end
    return r;
  endfunction

  logic [8:0]  nd_dot;
  logic [8:0]  nd_line;
  logic [13:0] pbase;
  logic        render;
  logic        in_window;

  // plain dot advance
  assign nd_dot  = (cur.dot >= ppu_sfs_pkg::LAST_DOT) ? 9'd0 : cur.dot + 9'd1;
  assign nd_line = (cur.dot >= ppu_sfs_pkg::LAST_DOT)
                 ? ((cur.line >= ppu_sfs_pkg::PRE_LINE) ? 9'd0 : cur.line + 9'd1)
                 : cur.line;

  assign render    = (cur.line < ppu_sfs_pkg::FIRST_IDLE) || (cur.line == ppu_sfs_pkg::PRE_LINE);
  assign in_window = ((cur.dot >= 9'd1) && (cur.dot <= ppu_sfs_pkg::WIN_A_END))
                   || (cur.dot >= ppu_sfs_pkg::WIN_B_START);
  // pattern base from the newest nametable byte and fine y
  assign pbase     = {1'b0, pattern_half, cur.name_sh[15:8], 1'b0, cur.v[14:12]};

  // one tick of the sequencer
  always_comb begin
    nxt   = cur;
    fetch = '0;
    fetch.kind = ppu_sfs_pkg::KIND_NONE;
    if (!render) begin
      nxt.dot  = nd_dot;
      nxt.line = nd_line;
      if ((nd_line == ppu_sfs_pkg::NMI_LINE) && (nd_dot == 9'd1)) begin
        nxt.nmi = 1'b1;
      end
    end else if ((cur.line == ppu_sfs_pkg::PRE_LINE) && (cur.dot == 9'd1)) begin
      fetch.clr = 1'b1;
      nxt.nmi   = 1'b0;
      nxt.dot   = nd_dot;
      nxt.line  = nd_line;
    end else begin
      if (in_window) begin
        case (cur.dot[2:0])
          ppu_sfs_pkg::PHASE_NAME: begin
            fetch.kind  = ppu_sfs_pkg::KIND_NAME;
            fetch.addr  = ppu_sfs_pkg::NAME_BASE | {2'b00, cur.v[11:0]};
            nxt.name_sh = {rd, cur.name_sh[15:8]};
          end
          ppu_sfs_pkg::PHASE_ATTR: begin
            fetch.kind  = ppu_sfs_pkg::KIND_ATTR;
            fetch.addr  = ppu_sfs_pkg::ATTR_BASE
                        | {2'b00, cur.v[11:10], 4'b0000, cur.v[9:7], cur.v[4:2]};
            nxt.attr_sh = {rd, cur.attr_sh[15:8]};
          end
          ppu_sfs_pkg::PHASE_PLO: begin
            fetch.kind  = ppu_sfs_pkg::KIND_PLO;
            fetch.addr  = pbase;
            nxt.plo_sh  = {rd, cur.plo_sh[15:8]};
          end
          ppu_sfs_pkg::PHASE_PHI: begin
            fetch.kind  = ppu_sfs_pkg::KIND_PHI;
            fetch.addr  = pbase | 14'h0008;
            nxt.phi_sh  = {rd, cur.phi_sh[15:8]};
            nxt.v       = (cur.dot == ppu_sfs_pkg::WIN_A_END) ? fine_y(cur.v) : coarse_x(cur.v);
          end
          default: begin
          end
        endcase
      end
      // copies from t
      if (cur.dot == ppu_sfs_pkg::HORI_DOT) begin
        nxt.v = (nxt.v & ~ppu_sfs_pkg::HORI_MASK) | (scroll_t & ppu_sfs_pkg::HORI_MASK);
      end
      if ((cur.line == ppu_sfs_pkg::PRE_LINE) && (cur.dot >= ppu_sfs_pkg::VERT_FIRST)
          && (cur.dot <= ppu_sfs_pkg::VERT_LAST)) begin
        nxt.v = (nxt.v & ~ppu_sfs_pkg::VERT_MASK) | (scroll_t & ppu_sfs_pkg::VERT_MASK);
      end
      // frame end skips a dot on odd frames
      if ((cur.line == ppu_sfs_pkg::PRE_LINE) && (cur.dot >= ppu_sfs_pkg::LAST_DOT)) begin
        nxt.dot  = {8'd0, cur.odd};
        nxt.line = 9'd0;
        nxt.odd  = ~cur.odd;
      end else begin
        nxt.dot  = nd_dot;
        nxt.line = nd_line;
      end
    end
  end

endmodule

FILE: tb/tb_ppu_scanline_fetch_sequencer.sv
// testbench for the scanline fetch sequencer: dot ticks against a tick-accurate predictor
`timescale 1ns / 1ps

module tb;

  // run limits
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int PHASE_ITEMS  = 160;
  localparam int END_SETTLE   = 8;
  localparam int PRINT_LIMIT  = 40;

  // register indexes the block ignores
  localparam logic [1:0] REG_UNUSED_A = 2'd2;
  localparam logic [1:0] REG_UNUSED_B = 2'd3;

  // scroll address field limits
  localparam logic [4:0] COL_MAX   = 5'd31;
  localparam logic [4:0] ROW_LAST  = 5'd29;
  localparam logic [4:0] ROW_MAX   = 5'd31;
  localparam logic [2:0] FINE_LAST = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // one result word as the block presents it
  typedef struct packed {
    logic [2:0]  kind;
    logic [13:0] addr;
    logic [8:0]  dot;
    logic [8:0]  line;
    logic [14:0] v;
    logic        nmi;
    logic        clr;
    logic [15:0] name_h;
    logic [15:0] attr_h;
    logic [15:0] plo_h;
    logic [15:0] phi_h;
  } tick_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_read_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_fetch_kind;
  logic [13:0] out_fetch_address;
  logic [8:0]  out_dot_now;
  logic [8:0]  out_line_now;
  logic [14:0] out_scroll_v;
  logic        out_nmi_active;
  logic        out_status_clear;
  logic [15:0] out_name_history;
  logic [15:0] out_attr_history;
  logic [15:0] out_plane_low_history;
  logic [15:0] out_plane_high_history;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [14:0] cfg_data = 15'd0;

  // predictor state and register copies
  ppu_sfs_pkg::state_t st = '0;
  logic [14:0] t_q = 15'd0;
  logic        half_q = 1'b0;

  tick_word_t  expected_q[$];
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          error_count = 0;
  int          ticks_checked = 0;
  int          cfg_writes = 0;
  int          frames_done = 0;
  int          odd_skips = 0;
  int          vblank_starts = 0;
  int          status_clears = 0;

  ppu_scanline_fetch_sequencer dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_read_data           (in_read_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_fetch_kind         (out_fetch_kind),
    .out_fetch_address      (out_fetch_address),
    .out_dot_now            (out_dot_now),
    .out_line_now           (out_line_now),
    .out_scroll_v           (out_scroll_v),
    .out_nmi_active         (out_nmi_active),
    .out_status_clear       (out_status_clear),
    .out_name_history       (out_name_history),
    .out_attr_history       (out_attr_history),
    .out_plane_low_history  (out_plane_low_history),
    .out_plane_high_history (out_plane_high_history),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic report_error(input string what);
    if (error_count < PRINT_LIMIT)
      $display("error: word %0d: %s", ticks_checked, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    tick_word_t got;
    tick_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_fetch_kind, out_fetch_address, out_dot_now, out_line_now, out_scroll_v,
              out_nmi_active, out_status_clear, out_name_history, out_attr_history,
              out_plane_low_history, out_plane_high_history};
      if (expected_q.size() == 0) begin
        report_error("result word with nothing expected");
      end else begin
        want = expected_q.pop_front();
        check_field("fetch_kind", 16'(got.kind), 16'(want.kind));
        check_field("fetch_address", 16'(got.addr), 16'(want.addr));
        check_field("dot_now", 16'(got.dot), 16'(want.dot));
        check_field("line_now", 16'(got.line), 16'(want.line));
        check_field("scroll_v", 16'(got.v), 16'(want.v));
        check_field("nmi_active", 16'(got.nmi), 16'(want.nmi));
        check_field("status_clear", 16'(got.clr), 16'(want.clr));
        check_field("name_history", got.name_h, want.name_h);
        check_field("attr_history", got.attr_h, want.attr_h);
        check_field("plane_low_history", got.plo_h, want.plo_h);
        check_field("plane_high_history", got.phi_h, want.phi_h);
      end
      ticks_checked++;
    end
  end

  // move to the next dot, wrapping the line and the frame
  function automatic void step_position();
    if (st.dot >= ppu_sfs_pkg::LAST_DOT) begin
      st.dot = 9'd0;
      st.line = (st.line >= ppu_sfs_pkg::PRE_LINE) ? 9'd0 : st.line + 9'd1;
    end else begin
      st.dot = st.dot + 9'd1;
    end
  endfunction

  // one dot tick of the fetch sequencer, returns the word it should produce
  function automatic tick_word_t advance_dot(input logic [7:0] data);
    tick_word_t  w;
    logic [8:0]  d;
    logic [8:0]  l;
    logic [13:0] pbase;
    logic [2:0]  fy;
    w = '0;
    d = st.dot;
    l = st.line;
    if (l >= ppu_sfs_pkg::FIRST_IDLE && l != ppu_sfs_pkg::PRE_LINE) begin
      // idle lines, vblank starts on dot 1 of the interrupt line
      step_position();
      if (st.line == ppu_sfs_pkg::NMI_LINE && st.dot == 9'd1) begin
        st.nmi = 1'b1;
        vblank_starts++;
      end
    end else if (l == ppu_sfs_pkg::PRE_LINE && d == 9'd1) begin
      w.clr = 1'b1;
      st.nmi = 1'b0;
      status_clears++;
      step_position();
    end else begin
      // fetch windows
      if ((d >= 9'd1 && d <= ppu_sfs_pkg::WIN_A_END) || d >= ppu_sfs_pkg::WIN_B_START) begin
        fy = st.v[14:12];
        pbase = {1'b0, half_q, st.name_sh[15:8], 4'b0000};
        case (d[2:0])
          ppu_sfs_pkg::PHASE_NAME: begin
            w.kind = ppu_sfs_pkg::KIND_NAME;
            w.addr = ppu_sfs_pkg::NAME_BASE | {2'b00, st.v[11:0]};
            st.name_sh = {data, st.name_sh[15:8]};
          end
          ppu_sfs_pkg::PHASE_ATTR: begin
            w.kind = ppu_sfs_pkg::KIND_ATTR;
            w.addr = ppu_sfs_pkg::ATTR_BASE
                   | {2'b00, st.v[11:10], 4'b0000, st.v[9:7], st.v[4:2]};
            st.attr_sh = {data, st.attr_sh[15:8]};
          end
          ppu_sfs_pkg::PHASE_PLO: begin
            w.kind = ppu_sfs_pkg::KIND_PLO;
            w.addr = pbase + {11'd0, fy};
            st.plo_sh = {data, st.plo_sh[15:8]};
          end
          ppu_sfs_pkg::PHASE_PHI: begin
            w.kind = ppu_sfs_pkg::KIND_PHI;
            w.addr = pbase + {11'd0, fy} + 14'd8;
            st.phi_sh = {data, st.phi_sh[15:8]};
            if (d == ppu_sfs_pkg::WIN_A_END) begin
              // fine y, carrying into coarse y
              if (st.v[14:12] != FINE_LAST) begin
                st.v[14:12] = st.v[14:12] + 3'd1;
              end else begin
                st.v[14:12] = 3'd0;
                if (st.v[9:5] == ROW_LAST) begin
                  st.v[9:5] = 5'd0;
                  st.v[11] = ~st.v[11];
                end else if (st.v[9:5] == ROW_MAX) begin
                  st.v[9:5] = 5'd0;
                end else begin
                  st.v[9:5] = st.v[9:5] + 5'd1;
                end
              end
            end else if (st.v[4:0] == COL_MAX) begin
              st.v[4:0] = 5'd0;
              st.v[10] = ~st.v[10];
            end else begin
              st.v[4:0] = st.v[4:0] + 5'd1;
            end
          end
          default: ;
        endcase
      end
      // copies from t
      if (d == ppu_sfs_pkg::HORI_DOT)
        st.v = (st.v & ~ppu_sfs_pkg::HORI_MASK) | (t_q & ppu_sfs_pkg::HORI_MASK);
      if (l == ppu_sfs_pkg::PRE_LINE && d >= ppu_sfs_pkg::VERT_FIRST
          && d <= ppu_sfs_pkg::VERT_LAST)
        st.v = (st.v & ~ppu_sfs_pkg::VERT_MASK) | (t_q & ppu_sfs_pkg::VERT_MASK);
      // frame end, odd frames skip dot 0
      if (l == ppu_sfs_pkg::PRE_LINE && d >= ppu_sfs_pkg::LAST_DOT) begin
        st.dot = st.odd ? 9'd1 : 9'd0;
        st.line = 9'd0;
        if (st.odd)
          odd_skips++;
        st.odd = ~st.odd;
        frames_done++;
      end else begin
        step_position();
      end
    end
    w.dot = st.dot;
    w.line = st.line;
    w.v = st.v;
    w.nmi = st.nmi;
    w.name_h = st.name_sh;
    w.attr_h = st.attr_sh;
    w.plo_h = st.plo_sh;
    w.phi_h = st.phi_sh;
    return w;
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 50; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 50; end
      default:       begin gap_pct = 27; stall_pct = 27; end
    endcase
  endtask

  // send one tick word, with an optional random gap in front
  task automatic send_tick(input logic [7:0] data);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_read_data <= data;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    expected_q.push_back(advance_dot(data));
  endtask

  // hold the sender off until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      ppu_sfs_pkg::REG_SCROLL_T:     t_q = val;
      ppu_sfs_pkg::REG_PATTERN_HALF: half_q = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // both registers, then an index the block must ignore
  task automatic write_regs(input logic [14:0] t_val, input logic [14:0] half_val);
    put_reg(2'(ppu_sfs_pkg::REG_SCROLL_T), t_val);
    put_reg(2'(ppu_sfs_pkg::REG_PATTERN_HALF), half_val);
    put_reg(cfg_writes[0] ? REG_UNUSED_B : REG_UNUSED_A, 15'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // registers straight after reset
  task automatic test_register_access();
    write_regs(15'h7FFF, 15'h0001);
  endtask

  // first 24 dot ticks of line 0: extreme bytes for the first 12, random bytes after them
  task automatic test_fetch_groups();
    set_idling(IDLE_NONE);
    for (int k = 0; k < 24; k++) begin
      if (k < 12)
        send_tick(k[1] ? 8'hFF : 8'h00);
      else
        send_tick(8'($urandom));
    end
  endtask

  // random bytes under each idling pattern, registers changed between phases
  task automatic test_idle_phases();
    for (int m = 0; m < 4; m++) begin
      drain_results();
      case (m)
        0:       write_regs(15'h0000, 15'h7FFE);
        1:       write_regs(15'h7FFF, 15'h7FFF);
        default: write_regs(15'($urandom), 15'($urandom));
      endcase
      set_idling(idle_mode_e'(m));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(7) == 0)
          send_tick($urandom_range(1) ? 8'hFF : 8'h00);
        else
          send_tick(8'($urandom));
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_fetch_groups();
    test_idle_phases();
    set_idling(IDLE_NONE);
    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (expected_q.size() != 0)
      report_error($sformatf("%0d expected words never arrived", expected_q.size()));
    $display("summary: %0d ticks checked, %0d frame ends (%0d skipping a dot), %0d vblank starts",
             ticks_checked, frames_done, odd_skips, vblank_starts);
    $display("summary: %0d status clears, %0d register writes, %0d errors",
             status_clears, cfg_writes, error_count);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
